>>> rtl/tipq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tipq_pkg : timed item priority queue, shared definitions
// Sizes, codes and the entry type used by the cell row and the top level.
// ----------------------------------------------------------------------------
package tipq_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned ID_WIDTH = 32;
  localparam int unsigned TS_WIDTH = 48;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned LVLS     = $clog2(DEPTH);

  typedef logic [TS_WIDTH-1:0] ts_t;
  typedef logic [ID_WIDTH-1:0] id_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUP       = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic valid;
    ts_t  ts;
    id_t  id;
  } entry_t;

  // command broadcast along the row of cells
  typedef struct packed {
    logic cmp_en;  // latch match / order flags against the key
    logic ins_en;  // insert the key at its sorted place
    logic del_en;  // cells with their shift flag take the next entry
    ts_t  key_ts;
    id_t  key_id;
  } cell_cmd_t;

  // inclusive prefix OR, low index upwards, log-depth
  function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
    logic [DEPTH-1:0] r;
    r = v;
    for (int k = 0; k < LVLS; k++) begin
      r = r | (r << (1 << k));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/timed_item_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_item_priority_queue_unit : sorted priority queue with delete by id
// Row of shift cells kept in (timestamp, id) order; add, pop, remove.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   start / busy              operation, timestamp, item_id
//  result    result_valid_o (strobe)   status, popped_*, top_*, count
//
//  An item goes through three steps: capture, compare in every cell, shift update.
//  The result strobe comes in the cycle after the update; busy is low there,
//  so a new item can be taken alongside it.
//  Reset clears every cell and the count; the queue is usable at once.
//  Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module timed_item_priority_queue_unit
  import tipq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [47:0] timestamp_i,
  input  wire logic [31:0] item_id_i,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  output logic [47:0]      popped_timestamp_o,
  output logic [31:0]      popped_id_o,
  output logic             top_valid_o,
  output logic [47:0]      top_timestamp_o,
  output logic [31:0]      top_id_o,
  output logic [6:0]       count_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       op_q;
  ts_t              key_ts_q;
  id_t              key_id_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             res_valid_q;
  status_e          status_q, status_d;
  ts_t              pop_ts_q, pop_ts_d;
  id_t              pop_id_q, pop_id_d;

  cell_cmd_t        cmd;
  entry_t           cells   [DEPTH];
  logic [DEPTH-1:0] key_ahead;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] shift;
  logic             any_match, full, empty;
  logic             do_ins, do_del;

  assign busy      = (state_q != S_IDLE);
  assign any_match = |match;
  assign full      = cells[DEPTH-1].valid;
  assign empty     = !cells[0].valid;

  // decide the outcome during the update cycle
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    shift    = '0;
    status_d = ST_OK;
    pop_ts_d = '0;
    pop_id_d = '0;
    count_d  = count_q;
    case (op_q)
      OP_ADD: begin
        if (any_match) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_del   = 1'b1;
          shift    = '1;
          pop_ts_d = cells[0].ts;
          pop_id_d = cells[0].id;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!any_match) begin
          status_d = ST_NOT_FOUND;
        end else begin
          do_del  = 1'b1;
          shift   = prefix_or(match);
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign cmd = '{cmp_en: state_q == S_CMP,
                 ins_en: (state_q == S_UPD) && do_ins,
                 del_en: (state_q == S_UPD) && do_del,
                 key_ts: key_ts_q,
                 key_id: key_id_q};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_b;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_b = key_ahead[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[i+1];
    end
    tipq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .prev_i        (prev_e),
      .next_i        (next_e),
      .prev_before_i (prev_b),
      .shift_i       (shift[i]),
      .entry_o       (cells[i]),
      .before_o      (key_ahead[i]),
      .match_o       (match[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == S_UPD);
      if (state_q == S_UPD) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q     <= operation_i;
      key_ts_q <= timestamp_i;
      key_id_q <= id_t'(item_id_i);
    end
    if (state_q == S_UPD) begin
      pop_ts_q <= pop_ts_d;
      pop_id_q <= pop_id_d;
    end
  end

  // invalid cells hold zero, so the head reads zero when empty
  assign result_valid_o     = res_valid_q;
  assign status_o           = status_q;
  assign popped_timestamp_o = pop_ts_q;
  assign popped_id_o        = 32'(pop_id_q);
  assign top_valid_o        = cells[0].valid;
  assign top_timestamp_o    = cells[0].ts;
  assign top_id_o           = 32'(cells[0].id);
  assign count_o            = 7'(count_q);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(match))
    else $error("id held in more than one cell");

  a_head_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cells[0].valid == (count_q != '0)))
    else $error("head valid disagrees with count");

  a_strobe_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> result_valid_o && !busy)
    else $error("result strobe missing after update");

endmodule
`default_nettype wire

>>> rtl/tipq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tipq_cell : one slot of the sorted shift-cell row
// Holds one entry, flags id match and key ordering, shifts with neighbours.
// ----------------------------------------------------------------------------
module tipq_cell
  import tipq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_cmd_t cmd_i,
  input  wire entry_t    prev_i,
  input  wire entry_t    next_i,
  input  wire logic      prev_before_i,
  input  wire logic      shift_i,
  output entry_t         entry_o,
  output logic           before_o,
  output logic           match_o
);

  entry_t entry_q, entry_d;
  logic   before_q, before_d;
  logic   match_q, match_d;
  logic   key_earlier;

  // key strictly ahead of this entry: earlier time, or same time and smaller id
  assign key_earlier = (cmd_i.key_ts < entry_q.ts) ||
                       ((cmd_i.key_ts == entry_q.ts) && (cmd_i.key_id < entry_q.id));

  always_comb begin
    before_d = before_q;
    match_d  = match_q;
    entry_d  = entry_q;
    if (cmd_i.cmp_en) begin
      before_d = !entry_q.valid || key_earlier;
      match_d  = entry_q.valid && (entry_q.id == cmd_i.key_id);
    end
    if (cmd_i.ins_en && before_q) begin
      if (prev_before_i) begin
        entry_d = prev_i;
      end else begin
        entry_d = '{valid: 1'b1, ts: cmd_i.key_ts, id: cmd_i.key_id};
      end
    end else if (cmd_i.del_en && shift_i) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q  <= '0;
      before_q <= 1'b0;
      match_q  <= 1'b0;
    end else begin
      entry_q  <= entry_d;
      before_q <= before_d;
      match_q  <= match_d;
    end
  end

  assign entry_o  = entry_q;
  assign before_o = before_q;
  assign match_o  = match_q;

endmodule
`default_nettype wire
